/* rtl/pseudorange_linearization_top_assert.svh */
// Assertion macros for the pseudorange linearization block
`ifndef PSEUDORANGE_LINEARIZATION_TOP_ASSERT_SVH
`define PSEUDORANGE_LINEARIZATION_TOP_ASSERT_SVH

// Antecedent in this cycle implies consequent in this cycle
`define PLR_ASSERT_SAME(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed: label");

// Antecedent in this cycle implies consequent in the next cycle
`define PLR_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed: label");

`endif

/* rtl/plr_pkg.sv */
`default_nettype none
package plr_pkg;
   localparam int COORD_W = 36;
   localparam int PR_W    = 35;
   localparam int LOS_W   = 32;
   localparam int PRN_W   = 8;
   localparam int MAG_W   = 37;
   localparam int SUM_W   = 78;
   localparam int ROOT_W  = 39;
   localparam int SQ_REM_W = 42;
   localparam int DV_REM_W = 40;
   localparam int Q_W     = 31;
   localparam int MIS_W   = 41;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RX_X = 2'd0,
      CSR_RX_Y = 2'd1,
      CSR_RX_Z = 2'd2,
      CSR_BIAS = 2'd3
   } csr_idx_type;

   // Data handed along the square-root chain
   typedef struct packed {
      logic [SQ_REM_W-1:0] rem;
      logic [ROOT_W-1:0]   root;
      logic [SUM_W-1:0]    rad;
      logic [PR_W-1:0]     pr;
      logic [PRN_W-1:0]    prn;
      logic [2:0]          neg;
      logic [2:0][MAG_W-1:0] mag;
   } sq_type;

   // Data handed along the divider chain
   typedef struct packed {
      logic [2:0][DV_REM_W-1:0] rem;
      logic [ROOT_W-1:0]        r;
      logic [2:0][Q_W-1:0]      q;
      logic [COORD_W-1:0]       mis;
      logic [PRN_W-1:0]         prn;
      logic [2:0]               neg;
      logic                     zero;
   } dv_type;
endpackage
`default_nettype wire

/* rtl/plr_ifs.sv */
`default_nettype none
interface plr_req_if;
   logic                         valid;
   logic                         ready;
   logic signed [plr_pkg::COORD_W-1:0] sat_x;
   logic signed [plr_pkg::COORD_W-1:0] sat_y;
   logic signed [plr_pkg::COORD_W-1:0] sat_z;
   logic [plr_pkg::PR_W-1:0]     pseudorange;
   logic [plr_pkg::PRN_W-1:0]    prn_in;
   modport source (output valid, sat_x, sat_y, sat_z, pseudorange, prn_in, input ready);
   modport sink (input valid, sat_x, sat_y, sat_z, pseudorange, prn_in, output ready);
endinterface

interface plr_rsp_if;
   logic                         valid;
   logic                         ready;
   logic signed [plr_pkg::COORD_W-1:0] misclosure;
   logic signed [plr_pkg::LOS_W-1:0]   los_x;
   logic signed [plr_pkg::LOS_W-1:0]   los_y;
   logic signed [plr_pkg::LOS_W-1:0]   los_z;
   logic [plr_pkg::PRN_W-1:0]    prn_out;
   logic                         range_zero;
   modport source (output valid, misclosure, los_x, los_y, los_z, prn_out, range_zero,
                   input ready);
   modport sink (input valid, misclosure, los_x, los_y, los_z, prn_out, range_zero,
                 output ready);
endinterface

interface plr_csr_if;
   logic                           valid;
   logic                           ready;
   logic [plr_pkg::CSR_IDX_W-1:0]  index;
   logic [plr_pkg::COORD_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/plr_sqrt_cell.sv */
`default_nettype none
module plr_sqrt_cell (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            valid_in,
   input  wire plr_pkg::sq_type data_in,
   output logic                 valid_out,
   output plr_pkg::sq_type      data_out
);
   import plr_pkg::*;

   logic    valid_ff;
   sq_type  data_ff, data_nx_in;
   logic [SQ_REM_W-1:0] cur, trial;

   // Resolve one root bit from the next two radicand bits
   always_comb begin
      cur   = {data_in.rem[SQ_REM_W-3:0], data_in.rad[SUM_W-1 -: 2]};
      trial = {1'b0, data_in.root, 2'b01};
      data_nx_in = data_in;
      data_nx_in.rad = {data_in.rad[SUM_W-3:0], 2'b00};
      if (cur >= trial) begin
         data_nx_in.rem  = cur - trial;
         data_nx_in.root = {data_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         data_nx_in.rem  = cur;
         data_nx_in.root = {data_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         data_ff <= data_nx_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
endmodule
`default_nettype wire

/* rtl/plr_div_cell.sv */
`default_nettype none
module plr_div_cell #(
   parameter bit FIRST = 1'b0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            en,
   input  wire logic            valid_in,
   input  wire plr_pkg::dv_type data_in,
   output logic                 valid_out,
   output plr_pkg::dv_type      data_out
);
   import plr_pkg::*;

   logic    valid_ff;
   dv_type  data_ff, data_nx_in;
   logic [DV_REM_W-1:0] cur;

   // Resolve one quotient bit on each of the three lanes
   always_comb begin
      data_nx_in = data_in;
      for (int k = 0; k < 3; k++) begin
         cur = FIRST ? data_in.rem[k] : {data_in.rem[k][DV_REM_W-2:0], 1'b0};
         if (cur >= {1'b0, data_in.r}) begin
            data_nx_in.rem[k] = cur - {1'b0, data_in.r};
            data_nx_in.q[k]   = {data_in.q[k][Q_W-2:0], 1'b1};
         end else begin
            data_nx_in.rem[k] = cur;
            data_nx_in.q[k]   = {data_in.q[k][Q_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
      if (en) begin
         data_ff <= data_nx_in;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
endmodule
`default_nettype wire

/* rtl/pseudorange_linearization_top.sv */
// Throughput: one item per cycle while no result waits untaken.
// Square root and division are chains of one-bit cells.
// The whole pipeline advances together and holds while a result waits untaken.
// Reset (synchronous, active high) clears all valid bits and CSR registers to zero.
`default_nettype none
module pseudorange_linearization_top #(
   parameter int UNIT_FRAC_BITS = 30
) (
   input  wire logic clock,
   input  wire logic reset,
   plr_req_if.sink   req_ch,
   plr_rsp_if.source rsp_ch,
   plr_csr_if.sink   csr_ch
);
   import plr_pkg::*;

   localparam int SQ_N = ROOT_W;
   localparam int DV_N = UNIT_FRAC_BITS + 1;

   logic signed [COORD_W-1:0] rx_ff [3];
   logic signed [COORD_W-1:0] bias_ff;
   logic adv;

   // Configuration writes
   assign csr_ch.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_ff[0] <= '0;
         rx_ff[1] <= '0;
         rx_ff[2] <= '0;
         bias_ff  <= '0;
      end else if (csr_ch.valid) begin
         unique case (csr_idx_type'(csr_ch.index))
            CSR_RX_X: rx_ff[0] <= csr_ch.data;
            CSR_RX_Y: rx_ff[1] <= csr_ch.data;
            CSR_RX_Z: rx_ff[2] <= csr_ch.data;
            CSR_BIAS: bias_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   assign adv = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // Stage 1: differences and magnitudes
   logic v1_ff;
   logic [2:0] neg1_ff;
   logic [2:0][MAG_W-1:0] mag1_ff;
   logic [PR_W-1:0] pr1_ff;
   logic [PRN_W-1:0] prn1_ff;
   logic signed [MAG_W-1:0] d1 [3];
   logic signed [COORD_W-1:0] sat [3];

   assign sat[0] = req_ch.sat_x;
   assign sat[1] = req_ch.sat_y;
   assign sat[2] = req_ch.sat_z;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         d1[k] = {sat[k][COORD_W-1], sat[k]} - {rx_ff[k][COORD_W-1], rx_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_ch.valid;
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            neg1_ff[k] <= d1[k][MAG_W-1];
            mag1_ff[k] <= d1[k][MAG_W-1] ? MAG_W'(-d1[k]) : MAG_W'(d1[k]);
         end
         pr1_ff  <= req_ch.pseudorange;
         prn1_ff <= req_ch.prn_in;
      end
   end

   // Stage 2: partial products of the squares
   logic v2_ff;
   logic [2:0] neg2_ff;
   logic [2:0][MAG_W-1:0] mag2_ff;
   logic [PR_W-1:0] pr2_ff;
   logic [PRN_W-1:0] prn2_ff;
   logic [35:0] hh_ff [3];
   logic [36:0] hl_ff [3];
   logic [37:0] ll_ff [3];

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            hh_ff[k] <= 36'(mag1_ff[k][36:19] * mag1_ff[k][36:19]);
            hl_ff[k] <= 37'(mag1_ff[k][36:19] * mag1_ff[k][18:0]);
            ll_ff[k] <= 38'(mag1_ff[k][18:0] * mag1_ff[k][18:0]);
         end
         neg2_ff <= neg1_ff;
         mag2_ff <= mag1_ff;
         pr2_ff  <= pr1_ff;
         prn2_ff <= prn1_ff;
      end
   end

   // Stage 3: sum of squares
   logic v3_ff;
   sq_type sq3_ff;
   logic [SUM_W-1:0] sum3;

   always_comb begin
      sum3 = '0;
      for (int k = 0; k < 3; k++) begin
         sum3 = sum3 + ({42'd0, hh_ff[k]} << 38) + ({41'd0, hl_ff[k]} << 20)
                + {40'd0, ll_ff[k]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         sq3_ff.rem  <= '0;
         sq3_ff.root <= '0;
         sq3_ff.rad  <= sum3;
         sq3_ff.pr   <= pr2_ff;
         sq3_ff.prn  <= prn2_ff;
         sq3_ff.neg  <= neg2_ff;
         sq3_ff.mag  <= mag2_ff;
      end
   end

   // Square-root chain, one root bit per cell
   logic   sq_v [SQ_N+1];
   sq_type sq_d [SQ_N+1];
   assign sq_v[0] = v3_ff;
   assign sq_d[0] = sq3_ff;

   for (genvar i = 0; i < SQ_N; i++) begin : g_sq
      plr_sqrt_cell u_cell (
         .clock, .reset, .en(adv),
         .valid_in(sq_v[i]), .data_in(sq_d[i]),
         .valid_out(sq_v[i+1]), .data_out(sq_d[i+1])
      );
   end

   // Misclosure with saturation, then load the divider chain
   logic signed [MIS_W-1:0] mis_full;
   logic [COORD_W-1:0] mis_sat;
   dv_type dv_first;
   sq_type sq_last;
   assign sq_last = sq_d[SQ_N];

   always_comb begin
      mis_full = $signed({6'd0, sq_last.pr}) - $signed({2'd0, sq_last.root})
                 - $signed({{(MIS_W-COORD_W){bias_ff[COORD_W-1]}}, bias_ff});
      if (mis_full > $signed({{(MIS_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}}))
         mis_sat = {1'b0, {(COORD_W-1){1'b1}}};
      else if (mis_full < $signed({{(MIS_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}}))
         mis_sat = {1'b1, {(COORD_W-1){1'b0}}};
      else
         mis_sat = mis_full[COORD_W-1:0];
      for (int k = 0; k < 3; k++) begin
         dv_first.rem[k] = {3'd0, sq_last.mag[k]};
         dv_first.q[k]   = '0;
      end
      dv_first.r    = sq_last.root;
      dv_first.mis  = mis_sat;
      dv_first.prn  = sq_last.prn;
      dv_first.neg  = sq_last.neg;
      dv_first.zero = (sq_last.root == '0);
   end

   // Divider chain, one quotient bit per cell on three lanes
   logic   dv_v [DV_N+1];
   dv_type dv_d [DV_N+1];
   assign dv_v[0] = sq_v[SQ_N];
   assign dv_d[0] = dv_first;

   for (genvar i = 0; i < DV_N; i++) begin : g_dv
      plr_div_cell #(.FIRST(i == 0)) u_cell (
         .clock, .reset, .en(adv),
         .valid_in(dv_v[i]), .data_in(dv_d[i]),
         .valid_out(dv_v[i+1]), .data_out(dv_d[i+1])
      );
   end

   // Output register: apply sign and zero-range masking
   dv_type dv_last;
   logic signed [LOS_W-1:0] los_in [3];
   logic signed [LOS_W-1:0] los_ff [3];
   logic [COORD_W-1:0] mis_ff;
   logic [PRN_W-1:0] prn_ff;
   logic zero_ff;
   assign dv_last = dv_d[DV_N];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dv_last.zero) los_in[k] = '0;
         else if (dv_last.neg[k]) los_in[k] = -$signed({1'b0, dv_last.q[k]});
         else los_in[k] = $signed({1'b0, dv_last.q[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (adv) rsp_valid_ff <= dv_v[DV_N];
      if (adv) begin
         los_ff  <= los_in;
         mis_ff  <= dv_last.mis;
         prn_ff  <= dv_last.prn;
         zero_ff <= dv_last.zero;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.misclosure = mis_ff;
   assign rsp_ch.los_x      = los_ff[0];
   assign rsp_ch.los_y      = los_ff[1];
   assign rsp_ch.los_z      = los_ff[2];
   assign rsp_ch.prn_out    = prn_ff;
   assign rsp_ch.range_zero = zero_ff;

   // Checks
   localparam logic signed [LOS_W-1:0] LOS_MAX = LOS_W'(1) <<< UNIT_FRAC_BITS;

`include "pseudorange_linearization_top_assert.svh"

   `PLR_ASSERT_SAME(a_zero_los, clock, reset, rsp_valid_ff && zero_ff,
      los_ff[0] == '0 && los_ff[1] == '0 && los_ff[2] == '0)
   `PLR_ASSERT_NEXT(a_req_enters, clock, reset, req_ch.valid && req_ch.ready, v1_ff)
   `PLR_ASSERT_SAME(a_los_bound, clock, reset, rsp_valid_ff,
      los_ff[0] <= LOS_MAX && los_ff[0] >= -LOS_MAX && los_ff[1] <= LOS_MAX
      && los_ff[1] >= -LOS_MAX && los_ff[2] <= LOS_MAX && los_ff[2] >= -LOS_MAX)
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import plr_pkg::*;

   localparam int LATENCY = 74;
   localparam int N_RANDOM = 1820;

   typedef struct packed {
      logic [COORD_W-1:0] misclosure;
      logic [LOS_W-1:0]   los_x;
      logic [LOS_W-1:0]   los_y;
      logic [LOS_W-1:0]   los_z;
      logic [PRN_W-1:0]   prn;
      logic               range_zero;
   } row_result_type;

   typedef struct packed {
      logic [COORD_W-1:0] sat_x;
      logic [COORD_W-1:0] sat_y;
      logic [COORD_W-1:0] sat_z;
      logic [PR_W-1:0]    pseudorange;
      logic [PRN_W-1:0]   prn;
   } meas_type;

   typedef struct packed {
      logic        is_csr;
      csr_idx_type idx;
      logic [COORD_W-1:0] wdata;
      meas_type    meas;
      logic        known;
      row_result_type result;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   errors = 0;

   plr_req_if req_ch ();
   plr_rsp_if rsp_ch ();
   plr_csr_if csr_ch ();

   pseudorange_linearization_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // shadow of the linearization point
   logic [COORD_W-1:0] lin_point [4];
   row_result_type     pending_rows [$];
   stim_row_type       stim_table [$];
   int                 rsp_hold = 0;
   int                 max_gap = 6;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // floor square root of the squared distance
   function automatic logic [ROOT_W-1:0] range_root(logic [SUM_W-1:0] s);
      logic [ROOT_W-1:0] r;
      logic [ROOT_W-1:0] c;
      logic [SUM_W-1:0]  cc;
      r = '0;
      for (int i = ROOT_W - 1; i >= 0; i--) begin
         c = r | (39'd1 << i);
         cc = SUM_W'(c) * SUM_W'(c);
         if (cc <= s) r = c;
      end
      return r;
   endfunction

   // misclosure and design row about the current linearization point
   function automatic row_result_type linearize(meas_type m);
      row_result_type o;
      logic signed [COORD_W:0] d [3];
      logic [COORD_W:0]        mg [3];
      logic [SUM_W-1:0]        sq;
      logic [ROOT_W-1:0]       rng;
      logic signed [40:0]      mis;
      logic [66:0]             q;
      logic [LOS_W-1:0]        comp [3];
      logic [COORD_W-1:0]      sat [3];
      sat[0] = m.sat_x;
      sat[1] = m.sat_y;
      sat[2] = m.sat_z;
      sq = '0;
      for (int k = 0; k < 3; k++) begin
         d[k] = $signed({sat[k][COORD_W-1], sat[k]})
              - $signed({lin_point[k][COORD_W-1], lin_point[k]});
         mg[k] = d[k][COORD_W] ? -d[k] : d[k];
         sq += SUM_W'(mg[k]) * SUM_W'(mg[k]);
      end
      rng = range_root(sq);
      mis = $signed({6'b0, m.pseudorange}) - $signed({2'b0, rng})
          - $signed({{5{lin_point[CSR_BIAS][COORD_W-1]}}, lin_point[CSR_BIAS]});
      if (mis < -(41'sd1 <<< 35)) mis = -(41'sd1 <<< 35);
      if (mis > (41'sd1 <<< 35) - 1) mis = (41'sd1 <<< 35) - 1;
      for (int k = 0; k < 3; k++) begin
         q = (rng == 0) ? '0 : ({30'b0, mg[k]} << 30) / 67'(rng);
         comp[k] = d[k][COORD_W] ? -q[LOS_W-1:0] : q[LOS_W-1:0];
      end
      o.misclosure = mis[COORD_W-1:0];
      o.los_x = comp[0];
      o.los_y = comp[1];
      o.los_z = comp[2];
      o.prn = m.prn;
      o.range_zero = (rng == 0);
      return o;
   endfunction

   function automatic logic [COORD_W-1:0] rand_coord();
      return COORD_W'({$urandom, $urandom});
   endfunction

   function automatic void add_meas(meas_type m, logic known, row_result_type r);
      stim_row_type s;
      s = '0;
      s.meas = m;
      s.known = known;
      s.result = r;
      stim_table.insert(stim_table.size(), s);
   endfunction

   function automatic void add_csr(csr_idx_type idx, logic [COORD_W-1:0] v);
      stim_row_type s;
      s = '0;
      s.is_csr = 1'b1;
      s.idx = idx;
      s.wdata = v;
      stim_table.insert(stim_table.size(), s);
   endfunction

   task automatic wait_drained();
      while (pending_rows.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [COORD_W-1:0] v);
      csr_ch.valid = 1'b1;
      csr_ch.index = idx;
      csr_ch.data = v;
      do @(posedge clock); while (!csr_ch.ready);
      lin_point[idx] = v;
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // one measurement transfer, optionally with a typed-in result
   task automatic send_meas(meas_type m, logic known, row_result_type r);
      int gap;
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.sat_x = m.sat_x;
      req_ch.sat_y = m.sat_y;
      req_ch.sat_z = m.sat_z;
      req_ch.pseudorange = m.pseudorange;
      req_ch.prn_in = m.prn;
      do @(posedge clock); while (!req_ch.ready);
      pending_rows.insert(pending_rows.size(), known ? r : linearize(m));
      @(negedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ch.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_ch.ready = 1'b1;
      end
   end

   // compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      row_result_type got;
      row_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.misclosure = rsp_ch.misclosure;
         got.los_x = rsp_ch.los_x;
         got.los_y = rsp_ch.los_y;
         got.los_z = rsp_ch.los_z;
         got.prn = rsp_ch.prn_out;
         got.range_zero = rsp_ch.range_zero;
         if (pending_rows.size() == 0) begin
            $display("%0t: unexpected result %h", $realtime, got);
            errors++;
         end else begin
            want = pending_rows.pop_front();
            if (got.misclosure !== want.misclosure) begin
               $display("%0t: misclosure exp %h got %h", $realtime, want.misclosure,
                        got.misclosure);
               errors++;
            end
            if (got.los_x !== want.los_x) begin
               $display("%0t: los_x exp %h got %h", $realtime, want.los_x, got.los_x);
               errors++;
            end
            if (got.los_y !== want.los_y) begin
               $display("%0t: los_y exp %h got %h", $realtime, want.los_y, got.los_y);
               errors++;
            end
            if (got.los_z !== want.los_z) begin
               $display("%0t: los_z exp %h got %h", $realtime, want.los_z, got.los_z);
               errors++;
            end
            if (got.prn !== want.prn) begin
               $display("%0t: prn exp %h got %h", $realtime, want.prn, got.prn);
               errors++;
            end
            if (got.range_zero !== want.range_zero) begin
               $display("%0t: range_zero exp %b got %b", $realtime, want.range_zero,
                        got.range_zero);
               errors++;
            end
         end
         if ($urandom_range(0, 3) == 0) rsp_hold = 0;
         else rsp_hold = $urandom_range(0, 6);
      end
   end

   initial begin
      localparam logic [COORD_W-1:0] C_MAX = {1'b0, {35{1'b1}}};
      localparam logic [COORD_W-1:0] C_MIN = {1'b1, 35'b0};
      localparam logic [PR_W-1:0]    PR_MAX = '1;
      meas_type       m;
      row_result_type r;
      stim_row_type   s;
      int             near;

      req_ch.valid = 1'b0;
      req_ch.sat_x = '0;
      req_ch.sat_y = '0;
      req_ch.sat_z = '0;
      req_ch.pseudorange = '0;
      req_ch.prn_in = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_RX_X;
      csr_ch.data = '0;
      for (int k = 0; k < 4; k++) lin_point[k] = '0;

      // coincident with the reset point: zero range
      add_meas('{'0, '0, '0, '0, 8'd0}, 1'b1, '{'0, '0, '0, '0, 8'd0, 1'b1});
      // axis-aligned unit vectors
      add_meas('{36'd1 << 30, '0, '0, 35'd1 << 30, 8'd255}, 1'b1,
               '{'0, 32'd1 << 30, '0, '0, 8'd255, 1'b0});
      add_meas('{'0, -(36'd1 << 30), '0, '0, 8'd1}, 1'b1,
               '{-(36'd1 << 30), '0, -(32'd1 << 30), '0, 8'd1, 1'b0});
      add_meas('{'0, '0, 36'd1 << 34, PR_MAX, 8'h5a}, 1'b1,
               '{C_MAX - (36'd1 << 34), '0, '0, 32'd1 << 30, 8'h5a, 1'b0});
      add_meas('{C_MAX, C_MAX, C_MAX, PR_MAX, 8'ha5}, 1'b0, '0);
      add_meas('{C_MIN, C_MIN, C_MIN, '0, 8'h80}, 1'b0, '0);
      add_meas('{C_MAX, C_MIN, 36'd1, 35'd12345, 8'h7f}, 1'b0, '0);
      add_meas('{36'd1, '0, '0, '0, 8'd2}, 1'b0, '0);
      // negative bias extreme pushes the misclosure to the top rail
      add_csr(CSR_BIAS, C_MIN);
      add_meas('{'0, '0, '0, PR_MAX, 8'd3}, 1'b1, '{C_MAX, '0, '0, '0, 8'd3, 1'b1});
      // far receiver and positive bias: bottom rail
      add_csr(CSR_BIAS, C_MAX);
      add_csr(CSR_RX_X, C_MIN);
      add_csr(CSR_RX_Y, C_MIN);
      add_csr(CSR_RX_Z, C_MIN);
      add_meas('{C_MAX, C_MAX, C_MAX, '0, 8'd4}, 1'b0, '0);
      add_meas('{C_MIN, C_MIN, C_MIN, '0, 8'd5}, 1'b1,
               '{-C_MAX, '0, '0, '0, 8'd5, 1'b1});
      add_meas('{C_MIN, C_MAX, C_MIN, PR_MAX, 8'd6}, 1'b0, '0);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (stim_table[i]) begin
         s = stim_table[i];
         if (s.is_csr) begin
            req_ch.valid = 1'b0;
            wait_drained();
            write_csr(s.idx, s.wdata);
         end else begin
            send_meas(s.meas, s.known, s.result);
         end
      end

      // random phases, each with its own linearization point
      for (int ph = 0; ph < 10; ph++) begin
         req_ch.valid = 1'b0;
         wait_drained();
         for (int k = 0; k < 4; k++) begin
            case (ph)
               0: write_csr(csr_idx_type'(k), '0);
               1: write_csr(csr_idx_type'(k), C_MAX);
               2: write_csr(csr_idx_type'(k), C_MIN);
               default: write_csr(csr_idx_type'(k), rand_coord());
            endcase
         end
         max_gap = (ph % 3 == 2) ? 0 : 6;
         for (int n = 0; n < N_RANDOM / 10; n++) begin
            near = $urandom_range(0, 9);
            m.sat_x = rand_coord();
            m.sat_y = rand_coord();
            m.sat_z = rand_coord();
            if (near == 0) begin
               m.sat_x = lin_point[CSR_RX_X];
               m.sat_y = lin_point[CSR_RX_Y];
               m.sat_z = lin_point[CSR_RX_Z];
            end else if (near < 4) begin
               // small offsets around the receiver
               m.sat_x = lin_point[CSR_RX_X] + 36'($signed($urandom_range(0, 64)) - 32);
               m.sat_y = lin_point[CSR_RX_Y] + 36'($signed($urandom_range(0, 64)) - 32);
               m.sat_z = lin_point[CSR_RX_Z] + 36'($signed($urandom_range(0, 64)) - 32);
            end
            m.pseudorange = PR_W'({$urandom, $urandom});
            m.prn = PRN_W'($urandom);
            send_meas(m, 1'b0, '0);
         end
      end
      req_ch.valid = 1'b0;

      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
`default_nettype wire
